// File: hw/rtl/ptpc_pkg.sv
// Package for the triac phase PID regulator.
// Holds item and stage types, register indexes and fixed-point constants.
// No dependencies.
package ptpc_pkg;

	localparam int CHANNELS = 3;
	localparam int CH_W     = 2;
	localparam int TEMP_W   = 14;
	localparam int ERR_W    = 15;
	localparam int DIFF_W   = 16;
	localparam int SUM_W    = 32;
	localparam int GAIN_W   = 32;
	localparam int PWR_W    = 11;
	localparam int DLY_W    = 14;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam int PTERM_W  = GAIN_W + 1 + ERR_W;
	localparam int ITERM_W  = GAIN_W + 1 + SUM_W;
	localparam int DTERM_W  = GAIN_W + 1 + DIFF_W;
	localparam int ILIM_W   = 52;
	localparam int ACC_W    = 53;
	localparam int FRAC_W   = 24;

	localparam logic [PWR_W-1:0] FULL_SCALE = 11'd1600;
	localparam logic [17:0] DELAY_STEP = 18'd100;
	localparam logic signed [ILIM_W-1:0] INT_LIMIT = 52'sh4_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] POWER_LIMIT = 53'sd1600 <<< FRAC_W;

	localparam logic [GAIN_W-1:0] KP_RESET = 32'd6710886;
	localparam logic [GAIN_W-1:0] KI_RESET = 32'd839;
	localparam logic [GAIN_W-1:0] KD_RESET = 32'd50332;

	typedef enum logic [1:0] {
		REG_KP = 2'd0,
		REG_KI = 2'd1,
		REG_KD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic [CH_W-1:0]          channel;
		logic signed [TEMP_W-1:0] setpoint;
		logic signed [TEMP_W-1:0] measured_temp;
	} sample_t;

	typedef struct packed {
		logic [CH_W-1:0]          channel;
		logic                     oob;
		logic signed [ERR_W-1:0]  err;
		logic signed [SUM_W-1:0]  sum;
		logic signed [DIFF_W-1:0] diff;
	} err_stage_t;

	typedef struct packed {
		logic [CH_W-1:0]           channel;
		logic                      oob;
		logic signed [PTERM_W-1:0] pterm;
		logic signed [ITERM_W-1:0] iterm;
		logic signed [DTERM_W-1:0] dterm;
	} prod_stage_t;

endpackage

// File: hw/rtl/ptpc_if.sv
// Valid/ready channel interfaces for samples in and commands out.
// Depends on ptpc_pkg.
interface ptpc_sample_if import ptpc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          channel;
	logic signed [TEMP_W-1:0] setpoint;
	logic signed [TEMP_W-1:0] measured_temp;

	modport source (output valid, output channel, output setpoint, output measured_temp,
		input ready);
	modport sink (input valid, input channel, input setpoint, input measured_temp,
		output ready);
endinterface

interface ptpc_command_if import ptpc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CH_W-1:0]      out_channel;
	logic [PWR_W-1:0]     power_percent;
	logic [DLY_W-1:0]     fire_delay_us;

	modport source (output valid, output out_channel, output power_percent,
		output fire_delay_us, input ready);
	modport sink (input valid, input out_channel, input power_percent,
		input fire_delay_us, output ready);
endinterface

// File: hw/rtl/pid_triac_phase_command.sv
// Per-channel PID regulator for triac heater drive: top level.
// An accepted item passes the input, error, product, sum and result registers in turn.
// Throughput: one item per cycle while the command output is not stalled; five register stages with per-stage valid.
// Reset (arst_n low, asynchronous): pipeline emptied, error sums and last
// errors cleared for all channels, gains set to their default values.
module pid_triac_phase_command import ptpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ptpc_sample_if.sink       sample,
	ptpc_command_if.source    command,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	gains_t      gains;
	sample_t     in_data;
	logic        s2_valid;
	logic        s2_ready;
	err_stage_t  s2_data;
	logic        s3_valid;
	logic        s3_ready;
	prod_stage_t s3_data;

	assign in_data.channel       = sample.channel;
	assign in_data.setpoint      = sample.setpoint;
	assign in_data.measured_temp = sample.measured_temp;

	ptpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	ptpc_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.in_data  (in_data),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2_data  (s2_data)
	);

	ptpc_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains),
		.in_valid (s2_valid),
		.in_ready (s2_ready),
		.in_data  (s2_data),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_data  (s3_data)
	);

	ptpc_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s3_valid),
		.in_ready      (s3_ready),
		.in_data       (s3_data),
		.out_valid     (command.valid),
		.out_ready     (command.ready),
		.out_channel   (command.out_channel),
		.power_percent (command.power_percent),
		.fire_delay_us (command.fire_delay_us)
	);

endmodule

// File: hw/rtl/ptpc_cfg.sv
// APB-style register block holding the three PID gains.
// Depends on ptpc_pkg.
module ptpc_cfg import ptpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output gains_t            gains
);

	gains_t gains_q;
	logic   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign gains  = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp <= KP_RESET;
			gains_q.ki <= KI_RESET;
			gains_q.kd <= KD_RESET;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_KP: gains_q.kp <= pwdata;
				REG_KI: gains_q.ki <= pwdata;
				REG_KD: gains_q.kd <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_KP: prdata = gains_q.kp;
			REG_KI: prdata = gains_q.ki;
			REG_KD: prdata = gains_q.kd;
			default: prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/ptpc_state.sv
// Input register, per-channel error sum and last error, error stage register.
// Depends on ptpc_pkg.
module ptpc_state import ptpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sample_t    in_data,
	output logic       s2_valid,
	input  logic       s2_ready,
	output err_stage_t s2_data
);

	logic                                valid_s1;
	sample_t                             data_s1;
	logic                                valid_s2;
	err_stage_t                          data_s2;
	logic [CHANNELS-1:0][SUM_W-1:0]      err_sum_q;
	logic [CHANNELS-1:0][ERR_W-1:0]      last_err_q;

	logic                     ready_s1;
	logic                     ready_s2;
	logic                     adv;
	logic                     oob;
	logic signed [ERR_W-1:0]  err;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SUM_W-1:0]  sum_old;
	logic signed [ERR_W-1:0]  last_old;

	assign ready_s2 = !valid_s2 || s2_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign adv      = valid_s1 && ready_s2;
	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

	assign oob      = data_s1.channel >= CH_W'(CHANNELS);
	assign sum_old  = oob ? '0 : $signed(err_sum_q[data_s1.channel]);
	assign last_old = oob ? '0 : $signed(last_err_q[data_s1.channel]);
	assign err      = ERR_W'(data_s1.setpoint) - ERR_W'(data_s1.measured_temp);
	assign sum_wide = (SUM_W+1)'(sum_old) + (SUM_W+1)'(err);
	assign diff     = DIFF_W'(err) - DIFF_W'(last_old);

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_sat = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			err_sum_q  <= '0;
			last_err_q <= '0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (adv && !oob) begin
				err_sum_q[data_s1.channel]  <= sum_sat;
				last_err_q[data_s1.channel] <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1)
			data_s1 <= in_data;
		if (adv) begin
			data_s2.channel <= data_s1.channel;
			data_s2.oob     <= oob;
			data_s2.err     <= err;
			data_s2.sum     <= sum_sat;
			data_s2.diff    <= diff;
		end
	end

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s2_ready |=> valid_s2 && $stable(data_s2))
		else $error("error stage changed while stalled");

	a_oob_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		adv && oob |=> $stable(err_sum_q) && $stable(last_err_q))
		else $error("out of range channel changed state");

	a_last_err_written: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !oob |=> last_err_q[$past(data_s1.channel)] == $past(err))
		else $error("last error not updated");

	a_no_update_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(err_sum_q))
		else $error("error sum changed without an item");
`endif

endmodule

// File: hw/rtl/ptpc_mult.sv
// Product stage: P, I and D gain multiplications into a registered stage.
// Depends on ptpc_pkg.
module ptpc_mult import ptpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  gains_t      gains,
	input  logic        in_valid,
	output logic        in_ready,
	input  err_stage_t  in_data,
	output logic        s3_valid,
	input  logic        s3_ready,
	output prod_stage_t s3_data
);

	logic                       valid_s3;
	prod_stage_t                data_s3;
	logic signed [GAIN_W:0]     kp_s;
	logic signed [GAIN_W:0]     ki_s;
	logic signed [GAIN_W:0]     kd_s;
	logic signed [PTERM_W-1:0]  pterm;
	logic signed [ITERM_W-1:0]  iterm;
	logic signed [DTERM_W-1:0]  dterm;

	assign in_ready = !valid_s3 || s3_ready;
	assign s3_valid = valid_s3;
	assign s3_data  = data_s3;

	assign kp_s  = $signed({1'b0, gains.kp});
	assign ki_s  = $signed({1'b0, gains.ki});
	assign kd_s  = $signed({1'b0, gains.kd});
	assign pterm = PTERM_W'(kp_s) * PTERM_W'(in_data.err);
	assign iterm = ITERM_W'(ki_s) * ITERM_W'(in_data.sum);
	assign dterm = DTERM_W'(kd_s) * DTERM_W'(in_data.diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (in_ready)
			valid_s3 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3.channel <= in_data.channel;
			data_s3.oob     <= in_data.oob;
			data_s3.pterm   <= pterm;
			data_s3.iterm   <= iterm;
			data_s3.dterm   <= dterm;
		end
	end

endmodule

// File: hw/rtl/ptpc_out.sv
// Sum, clamp to the power range, firing delay and result register.
// Depends on ptpc_pkg.
module ptpc_out import ptpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  prod_stage_t       in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CH_W-1:0]   out_channel,
	output logic [PWR_W-1:0]  power_percent,
	output logic [DLY_W-1:0]  fire_delay_us
);

	logic                      valid_s4;
	logic [CH_W-1:0]           channel_s4;
	logic [PWR_W-1:0]          power_s4;
	logic                      valid_q;
	logic [CH_W-1:0]           channel_q;
	logic [PWR_W-1:0]          power_q;
	logic [DLY_W-1:0]          delay_q;

	logic                      ready_q;
	logic signed [ILIM_W-1:0]  ilim;
	logic signed [ACC_W-1:0]   acc;
	logic [PWR_W-1:0]          power;
	logic [17:0]               delay_full;

	assign ready_q  = !valid_q || out_ready;
	assign in_ready = !valid_s4 || ready_q;

	always_comb begin
		if (in_data.iterm > ITERM_W'(INT_LIMIT))
			ilim = INT_LIMIT;
		else if (in_data.iterm < -ITERM_W'(INT_LIMIT))
			ilim = -INT_LIMIT;
		else
			ilim = in_data.iterm[ILIM_W-1:0];
	end

	assign acc = ACC_W'(in_data.pterm) + ACC_W'(ilim) + ACC_W'(in_data.dterm);

	always_comb begin
		if (in_data.oob || acc <= 0)
			power = '0;
		else if (acc >= POWER_LIMIT)
			power = FULL_SCALE;
		else
			power = acc[FRAC_W+PWR_W-1:FRAC_W];
	end

	assign delay_full = 18'(FULL_SCALE - power_s4) * DELAY_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready)
				valid_s4 <= in_valid;
			if (ready_q)
				valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			channel_s4 <= in_data.channel;
			power_s4   <= power;
		end
		if (valid_s4 && ready_q) begin
			channel_q <= channel_s4;
			power_q   <= power_s4;
			delay_q   <= delay_full[DLY_W+3:4];
		end
	end

	assign out_valid     = valid_q;
	assign out_channel   = channel_q;
	assign power_percent = power_q;
	assign fire_delay_us = delay_q;

endmodule

// File: bench/tb_pid_triac_phase_command.sv
// Self-checking bench for the triac phase PID regulator: drives samples and
// register writes, predicts each power command and checks it field by field.
// Depends on ptpc_pkg, ptpc_if.sv and pid_triac_phase_command.
module tb_pid_triac_phase_command;
	import ptpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 7;
	localparam int LATENCY = 4;
	localparam int DRAIN_LIMIT = 20000;
	localparam int REPORT_LIMIT = 40;
	localparam int REG_COUNT = REG_KD + 1;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int BURST_ITEMS = 40;
	localparam int HOLD_CYCLES = 120;
	localparam int INT_ROUNDS = 20;
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4 * REG_COUNT);
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};
	localparam longint SUM_HIGH = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_LOW = -(longint'(1) <<< (SUM_W - 1));

	typedef struct packed {
		logic [CH_W-1:0]  channel;
		logic [PWR_W-1:0] power;
		logic [DLY_W-1:0] delay;
	} heater_command_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	ptpc_sample_if sample_ch();
	ptpc_command_if command_ch();

	pid_triac_phase_command dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.command (command_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the block: gains and per-channel loop state
	logic [GAIN_W-1:0] gain_shadow [REG_COUNT] = '{KP_RESET, KI_RESET, KD_RESET};
	int error_sum_shadow [CHANNELS] = '{default: 0};
	int last_error_shadow [CHANNELS] = '{default: 0};
	heater_command_t predicted_commands [$];

	int mismatch_count = 0;
	bit sample_idling = 1'b0;
	bit sink_idling = 1'b0;
	int hold_request = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic heater_command_t predict_command(logic [CH_W-1:0] ch,
			logic signed [TEMP_W-1:0] sp, logic signed [TEMP_W-1:0] mt);
		heater_command_t res;
		longint err, sum, diff, integral, acc;
		int unsigned power;
		res.channel = ch;
		if (ch >= CHANNELS) begin
			res.power = '0;
			res.delay = DLY_W'((int'(FULL_SCALE) * int'(DELAY_STEP)) / 16);
			return res;
		end
		err = longint'(sp) - longint'(mt);
		sum = longint'(error_sum_shadow[ch]) + err;
		if (sum > SUM_HIGH)
			sum = SUM_HIGH;
		else if (sum < SUM_LOW)
			sum = SUM_LOW;
		error_sum_shadow[ch] = int'(sum);
		diff = err - longint'(last_error_shadow[ch]);
		last_error_shadow[ch] = int'(err);
		integral = longint'({32'd0, gain_shadow[REG_KI]}) * sum;
		if (integral > longint'(INT_LIMIT))
			integral = longint'(INT_LIMIT);
		else if (integral < -longint'(INT_LIMIT))
			integral = -longint'(INT_LIMIT);
		acc = longint'({32'd0, gain_shadow[REG_KP]}) * err + integral
			+ longint'({32'd0, gain_shadow[REG_KD]}) * diff;
		if (acc <= 0)
			power = 0;
		else if (acc >= (longint'(FULL_SCALE) <<< FRAC_W))
			power = FULL_SCALE;
		else
			power = int'(acc >>> FRAC_W);
		res.power = PWR_W'(power);
		res.delay = DLY_W'(((FULL_SCALE - power) * DELAY_STEP) / 16);
		return res;
	endfunction

	function automatic void report_mismatch(string field, logic [31:0] want,
			logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
	endfunction

	function automatic void check_command(heater_command_t got);
		heater_command_t want;
		if (predicted_commands.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t ns: no command expected, got channel %0d power %0d delay %0d",
					$time, got.channel, got.power, got.delay);
			return;
		end
		want = predicted_commands.pop_front();
		if (got.channel !== want.channel)
			report_mismatch("out_channel", want.channel, got.channel);
		if (got.power !== want.power)
			report_mismatch("power_percent", want.power, got.power);
		if (got.delay !== want.delay)
			report_mismatch("fire_delay_us", want.delay, got.delay);
	endfunction

	// register writes, accepted samples and finished commands, all at the edge
	always @(posedge clk) begin : track_block
		if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
				&& paddr[ADDR_W-1:2] <= REG_KD)
			gain_shadow[paddr[ADDR_W-1:2]] = pwdata;
		if (sample_ch.valid && sample_ch.ready)
			predicted_commands.push_back(predict_command(sample_ch.channel,
				sample_ch.setpoint, sample_ch.measured_temp));
		if (command_ch.valid && command_ch.ready)
			check_command('{command_ch.out_channel, command_ch.power_percent,
				command_ch.fire_delay_us});
	end

	function automatic int random_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	initial begin : drive_command_ready
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left = 0;
		command_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				command_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				command_ch.ready <= 1'b0;
			end else if (sink_idling && $urandom_range(0, 99) < 20) begin
				gap_left = random_gap() - 1;
				command_ch.ready <= 1'b0;
			end else begin
				command_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t r);
		return ADDR_W'(4 * int'(r));
	endfunction

	task automatic write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_register(reg_idx_t r);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= reg_addr(r);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== gain_shadow[r])
			report_mismatch("prdata", gain_shadow[r], prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
			logic [GAIN_W-1:0] kd);
		write_register(reg_addr(REG_KP), kp);
		write_register(reg_addr(REG_KI), ki);
		write_register(reg_addr(REG_KD), kd);
	endtask

	task automatic send_sample(int ch, int sp, int mt);
		if (sample_idling && $urandom_range(0, 99) < 25) begin
			sample_ch.valid <= 1'b0;
			repeat (random_gap()) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.channel <= CH_W'(ch);
		sample_ch.setpoint <= TEMP_W'(sp);
		sample_ch.measured_temp <= TEMP_W'(mt);
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic stop_samples();
		sample_ch.valid <= 1'b0;
	endtask

	function automatic int random_temp();
		if ($urandom_range(0, 99) < 85)
			return int'($urandom_range(0, 9215)) - 1024;
		return int'($urandom_range(0, 16383)) - 8192;
	endfunction

	task automatic send_random_sample();
		int ch, sp, mt;
		if ($urandom_range(0, 9) == 0)
			ch = $urandom_range(CHANNELS, (1 << CH_W) - 1);
		else
			ch = $urandom_range(0, CHANNELS - 1);
		sp = random_temp();
		if ($urandom_range(0, 9) < 6) begin
			mt = sp + int'($urandom_range(0, 600)) - 300;
			if (mt > TEMP_MAX)
				mt = TEMP_MAX;
			else if (mt < TEMP_MIN)
				mt = TEMP_MIN;
		end else begin
			mt = random_temp();
		end
		send_sample(ch, sp, mt);
	endtask

	task automatic wait_for_commands();
		int waited;
		waited = 0;
		while (predicted_commands.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic test_register_access();
		for (int i = 0; i < REG_COUNT; i++)
			read_register(reg_idx_t'(i));
		write_gains('1, '1, '1);
		for (int i = 0; i < REG_COUNT; i++)
			read_register(reg_idx_t'(i));
		write_gains('0, '0, '0);
		write_register(UNMAPPED_ADDR, '1);
		for (int i = 0; i < REG_COUNT; i++)
			read_register(reg_idx_t'(i));
		write_gains(KP_RESET, KI_RESET, KD_RESET);
		for (int i = 0; i < REG_COUNT; i++)
			read_register(reg_idx_t'(i));
	endtask

	task automatic test_directed_cases();
		sample_idling = 1'b0;
		sink_idling = 1'b0;
		send_sample(0, 0, 0);
		send_sample(0, 1000, 900);
		send_sample(0, 1010, 1000);
		send_sample(1, 8191, -1024);
		send_sample(1, -1024, 8191);
		send_sample(2, TEMP_MIN, TEMP_MAX);
		send_sample(2, TEMP_MAX, TEMP_MIN);
		send_sample(2, 400, 400);
		send_sample(3, TEMP_MAX, TEMP_MIN);
		send_sample(3, TEMP_MIN, TEMP_MAX);
		send_sample(0, 1020, 1000);
		send_sample(1, -1, 0);
		send_sample(1, 5000, 4990);
		send_sample(2, 2, 1);
		stop_samples();
		wait_for_commands();
		write_gains('1, '1, '1);
		send_sample(0, 1, 0);
		send_sample(1, 0, 1);
		send_sample(2, TEMP_MAX, TEMP_MIN);
		stop_samples();
		wait_for_commands();
		write_gains('0, '0, '0);
		send_sample(0, TEMP_MAX, TEMP_MIN);
		send_sample(1, TEMP_MIN, TEMP_MAX);
		send_sample(3, 0, 0);
		stop_samples();
		wait_for_commands();
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: write_gains(KP_RESET, KI_RESET, KD_RESET);
				1: write_gains('0, '0, '0);
				2: write_gains('1, '1, '1);
				default: begin
					write_gains(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1 << 24),
						$urandom_range(0, 1 << 16), $urandom_range(0, 1 << 22));
				end
			endcase
			sample_idling = (phase % 3) != 0;
			sink_idling = (phase % 4) != 0;
			repeat (ITEMS_PER_PHASE) send_random_sample();
			stop_samples();
			wait_for_commands();
		end
	endtask

	task automatic test_output_backpressure();
		write_gains(KP_RESET, KI_RESET, KD_RESET);
		sample_idling = 1'b0;
		sink_idling = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (BURST_ITEMS) send_random_sample();
		stop_samples();
		wait_for_commands();
	endtask

	task automatic test_integral_limit();
		sample_idling = 1'b0;
		sink_idling = 1'b0;
		// full integral gain pushes the integral term past its limit both ways
		write_gains('0, '1, '0);
		repeat (INT_ROUNDS) begin
			send_sample(0, TEMP_MAX, TEMP_MIN);
			send_sample(1, TEMP_MIN, TEMP_MAX);
		end
		send_sample(0, TEMP_MIN, TEMP_MAX);
		send_sample(1, TEMP_MAX, TEMP_MIN);
		send_sample(1, TEMP_MAX, TEMP_MIN);
		send_sample(0, TEMP_MAX, TEMP_MIN);
		stop_samples();
		wait_for_commands();
		write_gains('1, '1, '1);
		send_sample(0, 0, 1);
		send_sample(1, 1, 0);
		send_sample(2, 100, 100);
		stop_samples();
		wait_for_commands();
		write_gains(KP_RESET, KI_RESET, KD_RESET);
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.channel = '0;
		sample_ch.setpoint = '0;
		sample_ch.measured_temp = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed_cases();
		test_random_phases();
		test_output_backpressure();
		test_integral_limit();
		wait_for_commands();
		if (predicted_commands.size() != 0) begin
			mismatch_count += predicted_commands.size();
			$display("%0t ns: %0d commands expected, 0 arrived", $time,
				predicted_commands.size());
		end
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
